### hdl/countdown_timer_table_unit_macros.svh
// ---------------------------------------------------------------------------
// countdown_timer_table_unit macros
// Assertion helpers for the countdown timer table.
// ---------------------------------------------------------------------------
`ifndef COUNTDOWN_TIMER_TABLE_UNIT_MACROS_SVH
`define COUNTDOWN_TIMER_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define CTT_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CTT_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ctt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ctt_pkg
// Types and codes shared by the countdown timer table modules.
// ---------------------------------------------------------------------------
package ctt_pkg;

    localparam logic [2:0] KIND_TICK   = 3'd0;
    localparam logic [2:0] KIND_ADD    = 3'd1;
    localparam logic [2:0] KIND_QUERY  = 3'd2;
    localparam logic [2:0] KIND_RESET  = 3'd3;
    localparam logic [2:0] KIND_REMOVE = 3'd4;
    localparam logic [2:0] KIND_CANCEL = 3'd5;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    localparam logic [15:0] PERIOD_RESET = 16'd1000;
    localparam logic [31:0] COUNT_MIN    = 32'h8000_0000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic [15:0]        tag;
        logic signed [31:0] count;
    } entry_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        given_id;
        logic signed [31:0] remaining;
        logic               finished;
    } result_t;

endpackage

### hdl/ctt_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ctt_ram
// Timer entry store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module ctt_ram import ctt_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem_reg [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/ctt_seq.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ctt_seq
// Command sequencer: walks the entry store at most once per item, holds live bits
// and the identifier counter, and builds the result.
// ---------------------------------------------------------------------------
module ctt_seq import ctt_pkg::*; #(
    parameter int TIMERS = 16,
    parameter int IDX_W  = 4,
    parameter int CNT_W  = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [2:0]       kind,
    input  logic [15:0]      timer_id,
    input  logic [31:0]      duration,
    input  logic [15:0]      period,
    output logic             res_valid,
    input  logic             res_take,
    output result_t          res,
    output logic             mem_we,
    output logic [IDX_W-1:0] mem_waddr,
    output entry_t           mem_wdata,
    output logic [IDX_W-1:0] mem_raddr,
    input  entry_t           mem_rdata
);

    seq_state_t        state_reg, state_next;
    logic [2:0]        kind_reg, kind_next;
    logic [15:0]       id_reg, id_next;
    logic [31:0]       dur_reg, dur_next;
    logic [TIMERS-1:0] live_reg, live_next;
    logic [15:0]       next_tag_reg, next_tag_next;
    logic [CNT_W-1:0]  rd_cnt_reg, rd_cnt_next;
    logic              p_vld_reg, p_vld_next;
    logic [IDX_W-1:0]  p_idx_reg, p_idx_next;
    result_t           res_reg, res_next;

    logic              issue;
    logic              hit;
    logic              cur_live;
    logic              cur_match;
    logic              p_last;
    logic [32:0]       diff;
    logic [31:0]       ticked;

    assign cur_live  = live_reg[p_idx_reg];
    assign cur_match = cur_live && (mem_rdata.tag == id_reg);
    assign p_last    = (p_idx_reg == IDX_W'(TIMERS - 1));
    assign diff      = {mem_rdata.count[31], mem_rdata.count} - {17'd0, period};
    assign ticked    = (diff[32] != diff[31]) ? COUNT_MIN : diff[31:0];

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;
    assign mem_raddr = rd_cnt_reg[IDX_W-1:0];
    assign mem_waddr = p_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            live_reg     <= '0;
            next_tag_reg <= '0;
            rd_cnt_reg   <= '0;
            p_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            live_reg     <= live_next;
            next_tag_reg <= next_tag_next;
            rd_cnt_reg   <= rd_cnt_next;
            p_vld_reg    <= p_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        id_reg    <= id_next;
        dur_reg   <= dur_next;
        p_idx_reg <= p_idx_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        id_next       = id_reg;
        dur_next      = dur_reg;
        live_next     = live_reg;
        next_tag_next = next_tag_reg;
        rd_cnt_next   = rd_cnt_reg;
        p_vld_next    = p_vld_reg;
        p_idx_next    = p_idx_reg;
        res_next      = res_reg;
        issue         = 1'b0;
        hit           = 1'b0;
        mem_we        = 1'b0;
        mem_wdata     = mem_rdata;

        case (state_reg)
            ST_IDLE:
            begin
                p_vld_next  = 1'b0;
                rd_cnt_next = '0;
                if (in_valid)
                begin
                    kind_next = kind;
                    id_next   = timer_id;
                    dur_next  = duration;
                    res_next  = '{status: STAT_OK, given_id: timer_id,
                                  remaining: '0, finished: 1'b0};
                    case (kind)
                        KIND_CANCEL:
                        begin
                            live_next     = '0;
                            next_tag_next = '0;
                            state_next    = ST_DONE;
                        end
                        KIND_TICK, KIND_ADD, KIND_QUERY, KIND_RESET, KIND_REMOVE:
                        begin
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                issue       = (rd_cnt_reg < CNT_W'(TIMERS));
                rd_cnt_next = rd_cnt_reg + CNT_W'(issue);
                p_vld_next  = issue;
                p_idx_next  = rd_cnt_reg[IDX_W-1:0];
                if (p_vld_reg)
                begin
                    case (kind_reg)
                        KIND_TICK:
                        begin
                            if (cur_live)
                            begin
                                mem_we          = 1'b1;
                                mem_wdata.count = ticked;
                            end
                        end
                        KIND_ADD:
                        begin
                            if (!cur_live)
                            begin
                                hit                  = 1'b1;
                                mem_we               = 1'b1;
                                mem_wdata            = '{tag: next_tag_reg, count: dur_reg};
                                live_next[p_idx_reg] = 1'b1;
                                res_next.given_id    = next_tag_reg;
                                next_tag_next        = next_tag_reg + 16'd1;
                            end
                        end
                        KIND_QUERY:
                        begin
                            if (cur_match)
                            begin
                                hit                = 1'b1;
                                res_next.remaining = mem_rdata.count;
                                res_next.finished  = mem_rdata.count[31] ||
                                                     (mem_rdata.count == 32'sd0);
                            end
                        end
                        KIND_RESET:
                        begin
                            if (cur_match)
                            begin
                                hit             = 1'b1;
                                mem_we          = 1'b1;
                                mem_wdata.count = dur_reg;
                            end
                        end
                        KIND_REMOVE:
                        begin
                            if (cur_match)
                            begin
                                hit                  = 1'b1;
                                live_next[p_idx_reg] = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    if (hit)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (p_last)
                    begin
                        state_next = ST_DONE;
                        case (kind_reg)
                            KIND_ADD:
                            begin
                                res_next.status = STAT_FULL;
                            end
                            KIND_QUERY, KIND_RESET, KIND_REMOVE:
                            begin
                                res_next.status = STAT_MISS;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/countdown_timer_table_unit.sv
`timescale 1ns / 1ps
// Tick, add, query, reset and remove walk the entry store one entry per
// cycle through its single read port, up to all TIMERS entries; a lookup
// or add ends the walk early when it hits. Cancel all and unused kinds
// skip the walk. One item is in work at a time, so the next item is
// accepted no earlier than the cycle its result is taken.
// Reset: all timers dead, identifier counter 0, update period 1000.
// ---------------------------------------------------------------------------
// countdown_timer_table_unit
// Table of countdown timers tagged by wrapping identifiers; top level with
// configuration register and result register.
// ---------------------------------------------------------------------------
`include "countdown_timer_table_unit_macros.svh"

module countdown_timer_table_unit import ctt_pkg::*; #(
    parameter int TIMERS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  kind,
    input  logic [15:0] timer_id,
    input  logic [31:0] duration,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [15:0] given_id,
    output logic [31:0] remaining,
    output logic        finished
);

    localparam int IDX_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int CNT_W = $clog2(TIMERS + 1);

    logic [15:0]      period_reg;
    logic             out_valid_reg, out_valid_next;
    result_t          out_res_reg;

    logic             res_valid;
    logic             res_take;
    logic             res_load;
    result_t          res;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    entry_t           mem_rdata;

    assign cfg_ready = 1'b1;
    assign res_take  = !out_valid_reg || out_ready;
    assign res_load  = res_valid && res_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= PERIOD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                period_reg <= cfg_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_res_reg <= res;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_res_reg.status;
    assign given_id  = out_res_reg.given_id;
    assign remaining = out_res_reg.remaining;
    assign finished  = out_res_reg.finished;

    ctt_seq #(
        .TIMERS (TIMERS),
        .IDX_W  (IDX_W),
        .CNT_W  (CNT_W)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .timer_id  (timer_id),
        .duration  (duration),
        .period    (period_reg),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    ctt_ram #(
        .DEPTH (TIMERS),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    `CTT_ASSERT_NEXT(a_res_loaded, res_valid && res_take, out_valid, "result not loaded")
    `CTT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")
    `CTT_ASSERT_NOW(a_fail_clean, out_valid && (status != STAT_OK),
                    (remaining == 32'd0) && !finished, "failed result carries a count")
    `CTT_ASSERT_NOW(a_status_code, out_valid,
                    (status == STAT_OK) || (status == STAT_MISS) || (status == STAT_FULL),
                    "bad status code")

endmodule
